>>> hdl/cicf_pkg.sv
// Shared types and constants for the CAN identifier cooldown filter.
// Holds the transfer structs, verdict codes and the identifier ROM.
// No dependencies.
`timescale 1ns / 1ps

package cicf_pkg;

  localparam int unsigned ID_W       = 29;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned ROM_AW     = 6;   // covers the largest supported table
  localparam int unsigned LISTED_IDS = 12;

  localparam logic [TIME_W-1:0] COOLDOWN_TICKS = 32'd100;

  typedef logic [1:0] verdict_t;
  localparam verdict_t VERDICT_OK       = 2'd0;
  localparam verdict_t VERDICT_COOLDOWN = 2'd1;
  localparam verdict_t VERDICT_UNKNOWN  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   frame_id;
    logic [TIME_W-1:0] now_ms;
  } cicf_in_t;

  typedef struct packed {
    logic     accepted;
    verdict_t verdict;
  } cicf_out_t;

  typedef struct packed {
    logic            present;
    logic [ID_W-1:0] id;
  } id_entry_t;

  localparam logic [ID_W-1:0] ID_LIST [0:LISTED_IDS-1] = '{
    29'h0C1, 29'h0C2, 29'h0C3, 29'h0C4, 29'h0C5, 29'h0C6,
    29'h0C7, 29'h0C8, 29'h0C9, 29'h0CA, 29'h0CB, 29'h01A
  };

  // Slots past the listed identifiers hold nothing and never match.
  function automatic id_entry_t id_rom(input logic [ROM_AW-1:0] idx);
    id_entry_t e;
    e.present = 1'b0;
    e.id      = '0;
    if (idx < ROM_AW'(LISTED_IDS)) begin
      e.present = 1'b1;
      e.id      = ID_LIST[idx[3:0]];
    end
    return e;
  endfunction

endpackage

>>> hdl/can_id_cooldown_filter.sv
// Top level of the CAN identifier cooldown filter: scan sequencer,
// compare/add unit and result register.
// Depends on cicf_pkg and cicf_time_store.
`timescale 1ns / 1ps

// Usage
//   Input: drive in_data (frame_id, now_ms) and raise start; the transfer
//   happens at a rising edge with start high and busy low. busy then stays
//   high until the verdict is issued.
//   Output: out_valid pulses for one cycle with out_data (accepted, verdict).
//   The receiver has no way to stall; it must take the result in that cycle.
//   Timing: one ROM entry is compared per cycle, starting at entry 0. A match
//   at entry k goes through scan, time fetch, check and a registered result;
//   an unknown identifier ends with its result registered once the last
//   entry has been scanned. The next item may start in the cycle out_valid
//   is high; no new item is taken while busy, so the identifier scan of
//   each item sets how soon the next can follow.
//   On a match the stored next-allowed time is compared to now_ms (plain
//   unsigned); if allowed it is rewritten as now_ms + 100 mod 2^32.
//   Reset: synchronous active-low; all next-allowed times read as zero
//   right after reset (valid bits, no clearing pass), sequencer idles.

module can_id_cooldown_filter
  import cicf_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  cicf_in_t  in_data,
  output logic      out_valid,
  output cicf_out_t out_data
);

  localparam int unsigned IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_CHECK = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  cicf_in_t          item_r;
  logic              out_valid_r, out_valid_nxt;
  cicf_out_t         out_data_r, out_data_nxt;

  id_entry_t         rom_e;
  logic              hit;
  logic [TIME_W-1:0] na_time;
  logic [TIME_W-1:0] sum;
  logic              too_early;
  logic              wr_en;

  // Time store; read address follows the scan index, so the entry of a hit
  // is ready in the CHECK cycle.
  cicf_time_store #(
    .DEPTH (NUM_ENTRIES),
    .AW    (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (idx_r),
    .rd_data (na_time),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (sum)
  );

  assign rom_e = id_rom(ROM_AW'(idx_r));
  assign hit   = rom_e.present && (rom_e.id == item_r.frame_id);

  // Shared compare/add unit
  assign too_early = item_r.now_ms < na_time;
  assign sum       = item_r.now_ms + COOLDOWN_TICKS;
  assign wr_en     = (state_r == ST_CHECK) && !too_early;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt = ST_CHECK;
        end else if (idx_r == LAST_IDX) begin
          state_nxt             = ST_IDLE;
          out_valid_nxt         = 1'b1;
          out_data_nxt.accepted = 1'b0;
          out_data_nxt.verdict  = VERDICT_UNKNOWN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_CHECK: begin
        state_nxt             = ST_IDLE;
        out_valid_nxt         = 1'b1;
        out_data_nxt.accepted = !too_early;
        out_data_nxt.verdict  = too_early ? VERDICT_COOLDOWN : VERDICT_OK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (state_r == ST_IDLE && start) begin
      item_r <= in_data;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // accepted flag and verdict code must agree
  a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.accepted == (out_data.verdict == VERDICT_OK)))
    else $error("accepted flag disagrees with verdict");

  // only the three defined verdict codes are issued
  a_no_code3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.verdict == VERDICT_OK) ||
                   (out_data.verdict == VERDICT_COOLDOWN) ||
                   (out_data.verdict == VERDICT_UNKNOWN)))
    else $error("illegal verdict code");

  // a started item keeps the block busy for at least the scan cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("no busy after transfer");

  // one verdict per item: never two strobes in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

endmodule

>>> hdl/cicf_time_store.sv
// Next-allowed time store: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on cicf_pkg.
`timescale 1ns / 1ps

module cicf_time_store
  import cicf_pkg::*;
#(
  parameter int unsigned DEPTH = 12,
  parameter int unsigned AW    = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [AW-1:0]     rd_addr,
  output logic [TIME_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [TIME_W-1:0] wr_data
);

  logic [TIME_W-1:0] mem [0:DEPTH-1];
  logic [DEPTH-1:0]  vld_r;
  logic [TIME_W-1:0] rd_data_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

>>> tb/sv/tb_can_id_cooldown_filter.sv
// Self-checking testbench for can_id_cooldown_filter: directed and random frames
// with an in-line per-identifier rate predictor and an in-order verdict check.
// Depends on cicf_pkg and the can_id_cooldown_filter RTL.
`timescale 1ns / 1ps

module tb_can_id_cooldown_filter;
  import cicf_pkg::*;

  // Table size under test; the predictor keeps its own copy of the ID ROM.
  localparam int unsigned TABLE_SIZE   = 12;
  localparam logic [TIME_W-1:0] HOLDOFF_MS = 32'd100;
  // Worst case is the longest scan per frame plus the longest sender gap,
  // summed over the 654 frames. Allow close to ten times that.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // Longest scan (unknown identifier) plus margin.
  localparam int unsigned DRAIN_CYCLES = TABLE_SIZE + 4;

  localparam logic [ID_W-1:0] KNOWN_IDS [0:TABLE_SIZE-1] = '{
    29'h0C1, 29'h0C2, 29'h0C3, 29'h0C4, 29'h0C5, 29'h0C6,
    29'h0C7, 29'h0C8, 29'h0C9, 29'h0CA, 29'h0CB, 29'h01A
  };

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  cicf_in_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  cicf_out_t out_data;

  // Predictor state: next tick at which each table entry may pass again.
  logic [TIME_W-1:0] release_ms [0:TABLE_SIZE-1];
  cicf_out_t         expected_verdicts [$];

  int unsigned cycle_count = 0;
  int unsigned mismatches  = 0;
  int unsigned n_frames    = 0;
  int unsigned n_passed    = 0;
  int unsigned n_held      = 0;
  int unsigned n_unknown   = 0;

  always #5 clk = ~clk;

  can_id_cooldown_filter #(
    .NUM_ENTRIES(TABLE_SIZE)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // First matching entry decides. Plain unsigned compare against the release
  // tick; a pass re-arms the entry at now + holdoff, wrapping mod 2^32.
  function automatic cicf_out_t rate_limit_verdict(input cicf_in_t frame);
    cicf_out_t res;
    res.accepted = 1'b0;
    res.verdict  = VERDICT_UNKNOWN;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      if (KNOWN_IDS[k] == frame.frame_id) begin
        if (frame.now_ms < release_ms[k]) begin
          res.verdict = VERDICT_COOLDOWN;
        end else begin
          release_ms[k] = frame.now_ms + HOLDOFF_MS;
          res.accepted  = 1'b1;
          res.verdict   = VERDICT_OK;
        end
        break;
      end
    end
    return res;
  endfunction

  // One frame transfer. Must be entered at a rising edge; start is left high
  // so back-to-back frames go out without a bubble.
  task automatic send_frame(input logic [ID_W-1:0] fid, input logic [TIME_W-1:0] now);
    cicf_in_t  frame;
    cicf_out_t want;
    frame.frame_id = fid;
    frame.now_ms   = now;
    start   <= 1'b1;
    in_data <= frame;
    // Transfer happens at the first edge that sees busy low.
    do @(posedge clk); while (busy);
    want = rate_limit_verdict(frame);
    expected_verdicts.push_back(want);
    n_frames++;
    case (want.verdict)
      VERDICT_OK:       n_passed++;
      VERDICT_COOLDOWN: n_held++;
      default:          n_unknown++;
    endcase
  endtask

  // Optional random sender gap so it lands on every scan position.
  task automatic maybe_idle(input int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
  endtask

  // Identifier extremes, a set high bit on a listed ID, and the identifier
  // just after the listed 0C1..0CB run.
  task automatic test_unknown_ids();
    send_frame('0, '0);
    send_frame('1, '1);
    send_frame(KNOWN_IDS[0] | (ID_W'(1) << (ID_W - 1)), 32'd5);
    send_frame(29'h0CC, 32'd5);
  endtask

  // Fresh after reset every entry reads zero, so each ID passes once.
  task automatic test_each_listed_id();
    for (int k = 0; k < TABLE_SIZE; k++)
      send_frame(KNOWN_IDS[k], TIME_W'(k));
  endtask

  // Entry 0 was re-armed at 100: one tick early is held, exactly on time
  // passes, and the fresh window holds again.
  task automatic test_cooldown_boundary();
    send_frame(KNOWN_IDS[0], 32'd99);
    send_frame(KNOWN_IDS[0], 32'd100);
    send_frame(KNOWN_IDS[0], 32'd150);
  endtask

  // Wrapped release tick lets the next frame straight through; a release
  // tick near the top blocks a wrapped clock until it climbs past it.
  // Leaves every entry with a small release tick.
  task automatic test_tick_wrap();
    send_frame(KNOWN_IDS[1], 32'hFFFF_FFF0);
    send_frame(KNOWN_IDS[1], 32'hFFFF_FFF5);
    send_frame(KNOWN_IDS[2], 32'hFFFF_FF00);
    send_frame(KNOWN_IDS[2], 32'd5);
    send_frame(KNOWN_IDS[2], 32'hFFFF_FFFF);
  endtask

  // Mostly listed IDs on a rising tick, so entries cycle through pass and
  // hold; the rest is out-of-order ticks, one-bit-off IDs and pure noise.
  task automatic test_random_traffic(input int unsigned n_items,
                                     input int unsigned idle_pct);
    logic [TIME_W-1:0] tick;
    logic [TIME_W-1:0] latest;
    logic [TIME_W-1:0] now;
    logic [ID_W-1:0]   fid;
    int unsigned       pick;
    latest = '0;
    foreach (release_ms[k])
      if (release_ms[k] > latest) latest = release_ms[k];
    // Random base so the high tick bits vary; lift it past any pending
    // window unless that would push it to the top of the range.
    tick = $urandom();
    if (tick < latest && latest < 32'hC000_0000) tick = latest;
    repeat (n_items) begin
      pick = $urandom_range(99);
      fid  = KNOWN_IDS[$urandom_range(TABLE_SIZE - 1)];
      now  = tick;
      if (pick < 65) begin
        tick += TIME_W'($urandom_range(20));
      end else if (pick < 75) begin
        now = tick + TIME_W'($urandom_range(600)) - 32'd300;
      end else if (pick < 77) begin
        now = $urandom();
      end else if (pick < 82) begin
        fid ^= ID_W'(1) << $urandom_range(ID_W - 1);
      end else begin
        fid = ID_W'($urandom());
        now = $urandom();
      end
      send_frame(fid, now);
      maybe_idle(idle_pct);
    end
  endtask

  // Results cannot be stalled: every out_valid cycle is a transfer and is
  // matched against the oldest outstanding frame.
  always @(posedge clk) begin : check_results
    cicf_out_t want;
    if (rst_n && out_valid) begin
      if (expected_verdicts.size() == 0) begin
        $error("result with no frame outstanding: accepted=%0d verdict=%0d",
               out_data.accepted, out_data.verdict);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_data.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_data.accepted);
          mismatches++;
        end
        if (out_data.verdict !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, out_data.verdict);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_verdicts.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    foreach (release_ms[k]) release_ms[k] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unknown_ids();
    test_each_listed_id();
    test_cooldown_boundary();
    test_tick_wrap();
    test_random_traffic(160, 0);
    test_random_traffic(160, 60);
    test_random_traffic(160, 32);
    test_random_traffic(150, 0);

    start <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    // Catch any stray result after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d frames sent with back-to-back and gapped starts: %0d passed,",
             n_frames, n_passed);
    $display("%0d held in cooldown, %0d unknown IDs; %0d mismatches",
             n_held, n_unknown, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/cicf_pkg.sv
hdl/cicf_time_store.sv
hdl/can_id_cooldown_filter.sv
tb/sv/tb_can_id_cooldown_filter.sv
